// File: rtl/sorted_key_rule_table_assert.svh
// Assertion macros for the rule table RTL; skrt_ctrl is the file that includes them.
// Needs clk_i and rst_ni in the scope where the macros are used.
`ifndef SORTED_KEY_RULE_TABLE_ASSERT_SVH
`define SORTED_KEY_RULE_TABLE_ASSERT_SVH

// Same-cycle implication.
`define SKRT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SKRT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/skrt_pkg.sv
// Package for the sorted key rule table: depth, codes and shared types.
// Used by skrt_cell, skrt_ctrl and sorted_key_rule_table.
package skrt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    FN_INS_INT = 2'd0,
    FN_INS_EXT = 2'd1,
    FN_LOOKUP  = 2'd2
  } skrt_func_e;

  typedef enum logic [2:0] {
    STS_INSERTED  = 3'd0,
    STS_DUPLICATE = 3'd1,
    STS_FULL      = 3'd2,
    STS_FOUND     = 3'd3,
    STS_NOT_FOUND = 3'd4
  } skrt_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_APPLY
  } skrt_state_e;

  typedef struct packed {
    logic signed [15:0] key;
    logic               ext;
    logic signed [31:0] id;
    logic signed [15:0] dest;
  } skrt_entry_t;

  // Strobes from the controller to every cell of the row.
  typedef struct packed {
    logic cmp;
    logic ins;
  } skrt_ctl_t;

endpackage

// File: rtl/skrt_cell.sv
// One slot of the sorted rule row: holds an entry and its compare flags.
// Depends on skrt_pkg.
module skrt_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  skrt_pkg::skrt_ctl_t ctl_i,
  input  logic signed [15:0]  key_i,
  input  skrt_pkg::skrt_entry_t new_i,
  input  logic                occ_i,
  input  logic                prev_lt_i,
  input  skrt_pkg::skrt_entry_t prev_i,
  output logic                lt_o,
  output logic                hit_o,
  output skrt_pkg::skrt_entry_t entry_o
);
  import skrt_pkg::*;

  skrt_entry_t entry_q;
  logic        lt_q;
  logic        hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q  <= 1'b0;
      hit_q <= 1'b0;
    end else if (ctl_i.cmp) begin
      lt_q  <= occ_i && (entry_q.key < key_i);
      hit_q <= occ_i && (entry_q.key == key_i);
    end
  end

  // Entries below the insert point stay; the slot at the insert point takes
  // the new rule and every slot above it takes its lower neighbor's entry.
  always_ff @(posedge clk_i) begin
    if (ctl_i.ins && !lt_q) begin
      entry_q <= prev_lt_i ? new_i : prev_i;
    end
  end

  assign lt_o    = lt_q;
  assign hit_o   = hit_q;
  assign entry_o = entry_q;

endmodule

// File: rtl/skrt_ctrl.sv
// Request sequencer, entry count and result register of the rule table.
// Depends on skrt_pkg and sorted_key_rule_table_assert.svh.
module skrt_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             func_i,
  input  logic signed [15:0]     source_key_i,
  input  logic signed [31:0]     data_id_i,
  input  logic signed [15:0]     dest_index_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [2:0]             status_o,
  output logic                   rule_external_o,
  output logic signed [31:0]     found_data_id_o,
  output logic signed [15:0]     found_dest_index_o,
  output skrt_pkg::skrt_ctl_t    ctl_o,
  output logic signed [15:0]     key_o,
  output skrt_pkg::skrt_entry_t  new_o,
  output logic [skrt_pkg::CNT_W-1:0] count_o,
  input  logic [skrt_pkg::TABLE_DEPTH-1:0] hit_i,
  input  skrt_pkg::skrt_entry_t [skrt_pkg::TABLE_DEPTH-1:0] entries_i
);
  import skrt_pkg::*;

  skrt_state_e        state_q, state_d;
  logic [1:0]         func_q;
  logic signed [15:0] key_q;
  logic signed [31:0] id_q;
  logic signed [15:0] dest_q;
  logic [CNT_W-1:0]   cnt_q;

  logic               out_valid_q;
  skrt_status_e       status_q;
  logic               ext_q;
  logic signed [31:0] fid_q;
  logic signed [15:0] fdest_q;

  logic               accept;
  logic               out_free;
  logic               apply_done;
  logic               is_ins;
  logic               any_hit;
  logic               full;
  skrt_entry_t        found;
  skrt_status_e       status_d;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign apply_done = (state_q == S_APPLY) && out_free;
  assign is_ins     = (func_q == FN_INS_INT) || (func_q == FN_INS_EXT);
  assign any_hit    = |hit_i;
  assign full       = cnt_q == CNT_W'(TABLE_DEPTH);

  // Keys are unique, so at most one cell reports a hit.
  always_comb begin
    found = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (hit_i[i]) begin
        found = found | entries_i[i];
      end
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = S_CMP;
      S_CMP:   state_d = S_APPLY;
      S_APPLY: begin
        if (out_free) begin
          state_d = accept ? S_CMP : S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_stall_o = 1'b1;
    ctl_o      = '0;
    unique case (state_q)
      S_IDLE:  in_stall_o = 1'b0;
      S_CMP:   ctl_o.cmp = 1'b1;
      S_APPLY: begin
        in_stall_o = !out_free;
        ctl_o.ins  = out_free && is_ins && !any_hit && !full;
      end
      default: in_stall_o = 1'b1;
    endcase
  end

  always_comb begin
    if (is_ins) begin
      if (any_hit) begin
        status_d = STS_DUPLICATE;
      end else if (full) begin
        status_d = STS_FULL;
      end else begin
        status_d = STS_INSERTED;
      end
    end else begin
      status_d = any_hit ? STS_FOUND : STS_NOT_FOUND;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ctl_o.ins) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (apply_done) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_i;
      key_q  <= source_key_i;
      id_q   <= data_id_i;
      dest_q <= dest_index_i;
    end
    if (apply_done) begin
      status_q <= status_d;
      if (!is_ins && any_hit) begin
        ext_q   <= found.ext;
        fid_q   <= found.ext ? found.id : '0;
        fdest_q <= found.dest;
      end else begin
        ext_q   <= 1'b0;
        fid_q   <= '0;
        fdest_q <= '0;
      end
    end
  end

  assign key_o      = key_q;
  assign new_o.key  = key_q;
  assign new_o.ext  = func_q == FN_INS_EXT;
  assign new_o.id   = (func_q == FN_INS_EXT) ? id_q : '0;
  assign new_o.dest = dest_q;
  assign count_o    = cnt_q;

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign rule_external_o    = ext_q;
  assign found_data_id_o    = fid_q;
  assign found_dest_index_o = fdest_q;

`include "sorted_key_rule_table_assert.svh"

  `SKRT_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(TABLE_DEPTH), "entry count overflow")
  `SKRT_ASSERT_IMP(a_hit_unique, state_q == S_APPLY, $onehot0(hit_i), "several cells hit")
  `SKRT_ASSERT_NXT(a_cnt_step, ctl_o.ins, cnt_q == $past(cnt_q) + CNT_W'(1), "count not stepped")
  `SKRT_ASSERT_IMP(a_out_src, $rose(out_valid_q), $past(state_q) == S_APPLY,
                   "result without an update cycle")

endmodule

// File: rtl/sorted_key_rule_table.sv
// Sorted rule table: a row of cells kept in ascending key order.
// A request is accepted, then the cell row compares its key in S_CMP, then the
// row shifts and writes in S_APPLY and the result is registered; the next request
// can be accepted as one is applied, and a waiting result holds both back.
// Reset clears the entry count and the sequencer; table contents are not cleared.
module sorted_key_rule_table (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         func_i,
  input  logic signed [15:0] source_key_i,
  input  logic signed [31:0] data_id_i,
  input  logic signed [15:0] dest_index_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         status_o,
  output logic               rule_external_o,
  output logic signed [31:0] found_data_id_o,
  output logic signed [15:0] found_dest_index_o
);
  import skrt_pkg::*;

  skrt_ctl_t                          ctl;
  logic signed [15:0]                 key;
  skrt_entry_t                        new_entry;
  logic [CNT_W-1:0]                   count;
  logic [TABLE_DEPTH-1:0]             occ;
  logic [TABLE_DEPTH-1:0]             lt;
  logic [TABLE_DEPTH-1:0]             hit;
  skrt_entry_t [TABLE_DEPTH-1:0]      entries;

  skrt_ctrl u_ctrl (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .func_i             (func_i),
    .source_key_i       (source_key_i),
    .data_id_i          (data_id_i),
    .dest_index_i       (dest_index_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .status_o           (status_o),
    .rule_external_o    (rule_external_o),
    .found_data_id_o    (found_data_id_o),
    .found_dest_index_o (found_dest_index_o),
    .ctl_o              (ctl),
    .key_o              (key),
    .new_o              (new_entry),
    .count_o            (count),
    .hit_i              (hit),
    .entries_i          (entries)
  );

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    logic        prev_lt;
    skrt_entry_t prev_entry;

    assign occ[g] = count > CNT_W'(g);

    // The bottom cell sees the new rule as its lower neighbor.
    if (g == 0) begin : g_first
      assign prev_lt    = 1'b0;
      assign prev_entry = new_entry;
    end else begin : g_rest
      assign prev_lt    = lt[g-1];
      assign prev_entry = entries[g-1];
    end

    skrt_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl),
      .key_i     (key),
      .new_i     (new_entry),
      .occ_i     (occ[g]),
      .prev_lt_i (prev_lt),
      .prev_i    (prev_entry),
      .lt_o      (lt[g]),
      .hit_o     (hit[g]),
      .entry_o   (entries[g])
    );
  end

endmodule

// File: tb/sv/sorted_key_rule_table_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for sorted_key_rule_table: inserts and lookups go in
// through a valid/stall driver and are checked against a local table predictor.
// Depends on skrt_pkg and the sorted_key_rule_table RTL only.
module sorted_key_rule_table_tb;
  import skrt_pkg::*;

  // The selector value that has no function of its own; the block treats it as a lookup.
  localparam logic [1:0] FN_SPARE = 2'd3;
  localparam int RANDOM_REQS = 800;

  typedef struct {
    logic [1:0]         func;
    logic signed [15:0] key;
    logic signed [31:0] id;
    logic signed [15:0] dest;
  } rule_req_t;

  typedef struct {
    skrt_status_e       status;
    logic               ext;
    logic signed [31:0] id;
    logic signed [15:0] dest;
  } rule_resp_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_func = '0;
  logic signed [15:0] in_key = '0;
  logic signed [31:0] in_id = '0;
  logic signed [15:0] in_dest = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         status;
  logic               rule_external;
  logic signed [31:0] found_data_id;
  logic signed [15:0] found_dest_index;

  // Predicted table contents, kept in ascending key order.
  logic signed [15:0] tbl_key  [TABLE_DEPTH];
  logic               tbl_ext  [TABLE_DEPTH];
  logic signed [31:0] tbl_id   [TABLE_DEPTH];
  logic signed [15:0] tbl_dest [TABLE_DEPTH];
  int                 rules_held = 0;

  rule_req_t  pending_reqs[$];
  rule_resp_t expected_results[$];
  rule_resp_t exp_resp;
  logic signed [15:0] used_keys[$];
  int total_reqs = 0;
  int reqs_accepted = 0;
  int fail_count = 0;
  int send_idle = 0;
  int stall_left = 0;
  int send_burst = 0;
  int stall_burst = 0;

  sorted_key_rule_table i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .func_i             (in_func),
    .source_key_i       (in_key),
    .data_id_i          (in_id),
    .dest_index_i       (in_dest),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .status_o           (status),
    .rule_external_o    (rule_external),
    .found_data_id_o    (found_data_id),
    .found_dest_index_o (found_dest_index)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Mostly short idle stretches, a few long ones, and now and then a burst with none.
  function automatic int pick_idle(inout int burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if (r < 3) begin
      burst = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // Applies one request to the predicted table and returns the result it should give.
  function automatic rule_resp_t predict_rule_result(rule_req_t req);
    rule_resp_t resp;
    int         pos;
    bit         hit;
    resp = '{STS_NOT_FOUND, 1'b0, '0, '0};
    pos = 0;
    while (pos < rules_held && tbl_key[pos] < req.key) pos++;
    hit = (pos < rules_held) && (tbl_key[pos] == req.key);
    if (req.func == FN_INS_INT || req.func == FN_INS_EXT) begin
      if (hit) begin
        resp.status = STS_DUPLICATE;
      end else if (rules_held >= TABLE_DEPTH) begin
        resp.status = STS_FULL;
      end else begin
        for (int i = rules_held; i > pos; i--) begin
          tbl_key[i]  = tbl_key[i-1];
          tbl_ext[i]  = tbl_ext[i-1];
          tbl_id[i]   = tbl_id[i-1];
          tbl_dest[i] = tbl_dest[i-1];
        end
        tbl_key[pos]  = req.key;
        tbl_ext[pos]  = (req.func == FN_INS_EXT);
        tbl_id[pos]   = (req.func == FN_INS_EXT) ? req.id : '0;
        tbl_dest[pos] = req.dest;
        rules_held++;
        resp.status = STS_INSERTED;
      end
    end else if (hit) begin
      resp.status = STS_FOUND;
      resp.ext    = tbl_ext[pos];
      resp.id     = tbl_ext[pos] ? tbl_id[pos] : '0;
      resp.dest   = tbl_dest[pos];
    end
    return resp;
  endfunction

  task automatic queue_req(logic [1:0] func, logic signed [15:0] key,
                           logic signed [31:0] id, logic signed [15:0] dest);
    rule_req_t req;
    req = '{func, key, id, dest};
    pending_reqs.push_back(req);
    used_keys.push_back(key);
  endtask

  // Favors keys already seen so that duplicates and hits are common.
  function automatic logic signed [15:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55 && used_keys.size() > 0) return used_keys[$urandom_range(0, used_keys.size() - 1)];
    if (r < 65) begin
      case ($urandom_range(0, 6))
        0: return 16'sh8000;
        1: return 16'sh8001;
        2: return -16'sd1;
        3: return 16'sd0;
        4: return 16'sd1;
        5: return 16'sh7ffe;
        default: return 16'sh7fff;
      endcase
    end
    return 16'($urandom());
  endfunction

  // Driver: a new request is presented only when the previous one was taken.
  always @(posedge clk_i or negedge rst_ni) begin
    rule_req_t req;
    if (!rst_ni) begin
      in_valid  <= 1'b0;
      send_idle <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        req = '{in_func, in_key, in_id, in_dest};
        expected_results.push_back(predict_rule_result(req));
        reqs_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (send_idle > 0) begin
          in_valid  <= 1'b0;
          send_idle <= send_idle - 1;
        end else if (pending_reqs.size() > 0) begin
          req = pending_reqs.pop_front();
          in_func   <= req.func;
          in_key    <= req.key;
          in_id     <= req.id;
          in_dest   <= req.dest;
          in_valid  <= 1'b1;
          send_idle <= pick_idle(send_burst);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each accepted result with the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding: status %0d", status);
          fail_count++;
        end else begin
          exp_resp = expected_results.pop_front();
          if (status !== exp_resp.status) begin
            $error("status: expected %0d, got %0d", exp_resp.status, status);
            fail_count++;
          end
          if (rule_external !== exp_resp.ext) begin
            $error("rule_external: expected %0d, got %0d", exp_resp.ext, rule_external);
            fail_count++;
          end
          if (found_data_id !== exp_resp.id) begin
            $error("found_data_id: expected %0d, got %0d", exp_resp.id, found_data_id);
            fail_count++;
          end
          if (found_dest_index !== exp_resp.dest) begin
            $error("found_dest_index: expected %0d, got %0d", exp_resp.dest,
                   found_dest_index);
            fail_count++;
          end
        end
      end
      if (stall_left > 0) begin
        out_stall  <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        out_stall  <= 1'b0;
        stall_left <= pick_idle(stall_burst);
      end
    end
  end

  initial begin
    int r;
    logic [1:0] func;

    // Directed requests: empty-table lookups, key and field extremes, duplicates,
    // found rules of both kinds, and the spare selector acting as a lookup.
    queue_req(FN_LOOKUP, 16'sd0, '0, '0);
    queue_req(FN_SPARE, 16'sh8000, 32'hffff_ffff, 16'hffff);
    queue_req(FN_INS_INT, 16'sd0, 32'h1234_5678, 16'sh7fff);
    queue_req(FN_INS_EXT, 16'sh8000, 32'h8000_0000, 16'sh8000);
    queue_req(FN_INS_EXT, 16'sh7fff, 32'h7fff_ffff, -16'sd1);
    queue_req(FN_INS_INT, -16'sd1, 32'hffff_ffff, 16'sd0);
    queue_req(FN_INS_INT, 16'sd1, 32'hffff_ffff, 16'sh5555);
    queue_req(FN_INS_EXT, 16'sd0, 32'h0bad_cafe, 16'sd7);
    queue_req(FN_LOOKUP, 16'sd0, 32'hffff_ffff, 16'hffff);
    queue_req(FN_LOOKUP, 16'sh8000, '0, '0);
    queue_req(FN_LOOKUP, 16'sh7fff, '0, '0);
    queue_req(FN_SPARE, -16'sd1, '0, '0);
    queue_req(FN_LOOKUP, 16'sd2, '0, '0);
    queue_req(FN_INS_EXT, 16'sh5555, 32'h5555_5555, 16'shaaaa);
    queue_req(FN_INS_INT, 16'shaaaa, 32'haaaa_aaaa, 16'sh5555);
    queue_req(FN_LOOKUP, 16'sh5555, '0, '0);
    queue_req(FN_LOOKUP, 16'shaaaa, '0, '0);
    queue_req(FN_INS_INT, 16'sh7fff, '0, 16'sd3);
    queue_req(FN_LOOKUP, 16'sd1, '0, '0);

    // Random requests. Enough fresh keys arrive to fill the table, after which
    // inserts of absent keys report a full table and present ones a duplicate.
    for (int n = 0; n < RANDOM_REQS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 40) func = FN_INS_INT;
      else if (r < 65) func = FN_INS_EXT;
      else if (r < 94) func = FN_LOOKUP;
      else func = FN_SPARE;
      queue_req(func, pick_key(), $urandom(), 16'($urandom()));
    end
    total_reqs = pending_reqs.size();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (reqs_accepted < total_reqs || expected_results.size() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

endmodule
